FILE: hdl/cau_pkg.sv
`default_nettype none
package cau_pkg;

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_MUL,
		ACT_DIV
	} act_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_DIVZ,
		ST_SAT
	} status_t;

endpackage
`default_nettype wire

FILE: hdl/complex_arith_unit.sv
// Complex ALU on signed fixed-point words (WORD_BITS wide, FRAC_BITS fraction bits): add,
// subtract, multiply and divide of two complex operands, one request per clock with busy
// always low. Each request gives one result, marked by a one-cycle done pulse; the receiver
// cannot stall, so results must be taken as they appear. The divider resolves one quotient
// bit per pipeline stage over WORD_BITS+1 stages, and every operation runs through the same
// depth so results leave in request order. Multiply and divide round to nearest with ties
// away from zero; parts out of range saturate and report the saturated status, and a zero
// divisor returns zero parts with its own status.
`default_nettype none
module complex_arith_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire        [1:0]             action,
	input  wire signed [WORD_BITS-1:0]   a_real,
	input  wire signed [WORD_BITS-1:0]   a_imag,
	input  wire signed [WORD_BITS-1:0]   b_real,
	input  wire signed [WORD_BITS-1:0]   b_imag,
	output logic signed [WORD_BITS-1:0]  r_real,
	output logic signed [WORD_BITS-1:0]  r_imag,
	output logic       [1:0]             status,
	output logic                         done
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;
	localparam int RW = 2 * W + 1;
	localparam int QW = W + 1;
	localparam int TW = 2 * W + F + 3;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [RW-1:0] rem;
		logic [QW-1:0] low;
	} part_t;

	typedef struct packed {
		act_t          act;
		logic          zero;
		logic [RW-1:0] d2;
		part_t         re;
		part_t         im;
	} item_t;

	// stage 1: products and add/sub
	logic                 v_s1;
	act_t                 act_s1;
	logic signed [PW-1:0] rr_s1, ii_s1, ri_s1, ir_s1, bbr_s1, bbi_s1;
	logic signed [W:0]    sre_s1, sim_s1;

	// stage 2: sums
	logic                 v_s2;
	act_t                 act_s2;
	logic signed [SW-1:0] re_s2, im_s2;
	logic [RW-1:0]        den_s2;

	// stage 3: sign and magnitude
	logic                 v_s3;
	act_t                 act_s3;
	logic                 nre_s3, nim_s3;
	logic [SW-1:0]        mre_s3, mim_s3;
	logic [RW-1:0]        den_s3;

	// stage 4 and divider stages
	logic                 v_sk   [0:QW];
	item_t                pipe_sk [0:QW];
	item_t                head;

	assign busy = 1'b0;

	function automatic part_t prep(logic neg, logic [SW-1:0] mag, act_t act,
			logic [RW-1:0] den);
		part_t         p;
		logic [TW-1:0] top;
		logic [TW-1:0] hi;
		logic [SW:0]   rnd;
		p   = '0;
		top = (TW'(mag) << (F + 1)) + TW'(den);
		hi  = top >> QW;
		rnd = (SW+1)'((SW+1)'(mag) + ((SW+1)'(1) << (F - 1))) >> F;
		p.neg = neg;
		case (act)
			ACT_DIV: begin
				p.ovf = hi >= TW'({den[RW-2:0], 1'b0});
				p.rem = RW'(hi);
				p.low = QW'(top);
			end
			ACT_MUL: begin
				p.rem = RW'(rnd);
			end
			default: begin
				p.rem = RW'(mag);
			end
		endcase
		return p;
	endfunction

	function automatic part_t div_step(part_t p, logic [RW-1:0] d, logic en);
		part_t       r;
		logic [RW:0] sh;
		logic [RW:0] diff;
		logic        ge;
		r    = p;
		sh   = {p.rem, p.low[QW-1]};
		diff = sh - {1'b0, d};
		ge   = sh >= {1'b0, d};
		if (en) begin
			r.rem = ge ? RW'(diff) : RW'(sh);
			r.low = {p.low[QW-2:0], ge};
		end
		return r;
	endfunction

	// returns {saturated, value}
	function automatic logic [W:0] narrow(part_t p, logic dv);
		logic [RW-1:0] mw;
		logic [RW-1:0] lim;
		logic [RW-1:0] tmp;
		logic          sat;
		logic [W-1:0]  val;
		mw  = dv ? RW'(p.low) : p.rem;
		lim = p.neg ? (RW'(1) << (W - 1)) : ((RW'(1) << (W - 1)) - RW'(1));
		sat = (dv & p.ovf) | (mw > lim);
		tmp = p.neg ? (~mw + RW'(1)) : mw;
		if (sat) begin
			val = p.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			val = tmp[W-1:0];
		end
		return {sat, val};
	endfunction

	always_comb begin
		head      = '0;
		head.act  = act_s3;
		head.zero = den_s3 == '0;
		head.d2   = {den_s3[RW-2:0], 1'b0};
		head.re   = prep(nre_s3, mre_s3, act_s3, den_s3);
		head.im   = prep(nim_s3, mim_s3, act_s3, den_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				v_sk[k] <= 1'b0;
			end
		end else begin
			v_s1    <= start & ~busy;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_sk[0] <= v_s3;
			for (int k = 1; k <= QW; k++) begin
				v_sk[k] <= v_sk[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= act_t'(action);
		rr_s1  <= a_real * b_real;
		ii_s1  <= a_imag * b_imag;
		ri_s1  <= a_real * b_imag;
		ir_s1  <= a_imag * b_real;
		bbr_s1 <= b_real * b_real;
		bbi_s1 <= b_imag * b_imag;
		if (act_t'(action) == ACT_SUB) begin
			sre_s1 <= a_real - b_real;
			sim_s1 <= a_imag - b_imag;
		end else begin
			sre_s1 <= a_real + b_real;
			sim_s1 <= a_imag + b_imag;
		end

		act_s2 <= act_s1;
		den_s2 <= RW'($unsigned(bbr_s1)) + RW'($unsigned(bbi_s1));
		case (act_s1)
			ACT_MUL: begin
				re_s2 <= SW'(rr_s1) - SW'(ii_s1);
				im_s2 <= SW'(ri_s1) + SW'(ir_s1);
			end
			ACT_DIV: begin
				re_s2 <= SW'(rr_s1) + SW'(ii_s1);
				im_s2 <= SW'(ir_s1) - SW'(ri_s1);
			end
			default: begin
				re_s2 <= SW'(sre_s1);
				im_s2 <= SW'(sim_s1);
			end
		endcase

		act_s3 <= act_s2;
		den_s3 <= den_s2;
		nre_s3 <= re_s2[SW-1];
		nim_s3 <= im_s2[SW-1];
		mre_s3 <= re_s2[SW-1] ? SW'(-re_s2) : SW'(re_s2);
		mim_s3 <= im_s2[SW-1] ? SW'(-im_s2) : SW'(im_s2);

		pipe_sk[0] <= head;
		for (int k = 1; k <= QW; k++) begin
			pipe_sk[k].act  <= pipe_sk[k-1].act;
			pipe_sk[k].zero <= pipe_sk[k-1].zero;
			pipe_sk[k].d2   <= pipe_sk[k-1].d2;
			pipe_sk[k].re   <= div_step(pipe_sk[k-1].re, pipe_sk[k-1].d2,
				pipe_sk[k-1].act == ACT_DIV);
			pipe_sk[k].im   <= div_step(pipe_sk[k-1].im, pipe_sk[k-1].d2,
				pipe_sk[k-1].act == ACT_DIV);
		end
	end

	// output register
	logic [W:0] nre, nim;
	logic       dv_out;

	always_comb begin
		dv_out = pipe_sk[QW].act == ACT_DIV;
		nre    = narrow(pipe_sk[QW].re, dv_out);
		nim    = narrow(pipe_sk[QW].im, dv_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sk[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (dv_out && pipe_sk[QW].zero) begin
			r_real <= '0;
			r_imag <= '0;
			status <= ST_DIVZ;
		end else begin
			r_real <= nre[W-1:0];
			r_imag <= nim[W-1:0];
			status <= (nre[W] | nim[W]) ? ST_SAT : ST_OK;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/cau_checker.sv
`default_nettype none
module cau_checker #(
	parameter int WORD_BITS = 32
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        start,
	input wire                        busy,
	input wire                        done,
	input wire [1:0]                  status,
	input wire signed [WORD_BITS-1:0] r_real,
	input wire signed [WORD_BITS-1:0] r_imag
);
	import cau_pkg::*;

	localparam int LAT = WORD_BITS + 6;

	// fixed latency from request to result
	a_lat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after request");

	a_lat_none: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without request");

	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DIVZ) |-> (r_real == '0 && r_imag == '0))
		else $error("divide by zero with nonzero parts");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_DIVZ || status == ST_SAT))
		else $error("bad status code");

endmodule

bind complex_arith_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import cau_pkg::*;

	localparam int W = 32;
	localparam int F = 16;
	localparam int LATENCY = 37;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		act_t act;
		logic signed [W-1:0] ar, ai, br, bi;
	} request_t;

	typedef struct {
		logic signed [W-1:0] re, im;
		status_t st;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic signed [W-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic signed [W-1:0] r_real, r_imag;
	logic [1:0] status;
	logic done;

	request_t pending[$];
	answer_t awaited[$];
	int errors = 0;
	int idle_cycles = 0;
	bit all_sent = 0;
	int burst_left = 0;
	int gap_left = 0;

	complex_arith_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
		.r_real(r_real), .r_imag(r_imag), .status(status), .done(done)
	);

	always #10 clk = ~clk;

	function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v, ref bit sat);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (W - 1)) - 1;
		lo = -(128'sd1 <<< (W - 1));
		if (v > hi) begin
			sat = 1;
			return hi[W-1:0];
		end
		if (v < lo) begin
			sat = 1;
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// round to nearest, ties away from zero
	function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
		logic signed [127:0] m;
		m = v < 0 ? -v : v;
		m = (m + (128'sd1 <<< (F - 1))) >>> F;
		return v < 0 ? -m : m;
	endfunction

	function automatic logic signed [127:0] round_quot(input logic signed [127:0] n,
			input logic signed [127:0] d);
		logic signed [127:0] m;
		m = n < 0 ? -n : n;
		m = ((m <<< (F + 1)) + d) / (d <<< 1);
		return n < 0 ? -m : m;
	endfunction

	function automatic answer_t complex_result(input request_t q);
		answer_t r;
		logic signed [127:0] ar, ai, br, bi, re, im, den;
		bit sat;
		sat = 0;
		ar = q.ar; ai = q.ai; br = q.br; bi = q.bi;
		case (q.act)
			ACT_ADD: begin
				re = ar + br; im = ai + bi;
			end
			ACT_SUB: begin
				re = ar - br; im = ai - bi;
			end
			ACT_MUL: begin
				re = round_shift(ar * br - ai * bi);
				im = round_shift(ar * bi + ai * br);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.re = '0; r.im = '0; r.st = ST_DIVZ;
					return r;
				end
				re = round_quot(ar * br + ai * bi, den);
				im = round_quot(ai * br - ar * bi, den);
			end
		endcase
		r.re = clamp(re, sat);
		r.im = clamp(im, sat);
		r.st = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic logic signed [W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return '0;
			3, 4: return $signed(W'($urandom_range(0, 1 << 20))) - (1 << 19);
			5: return 32'sd1 <<< F;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_request(input act_t a, input logic signed [W-1:0] ar, ai, br, bi);
		request_t q;
		q.act = a; q.ar = ar; q.ai = ai; q.br = br; q.bi = bi;
		pending.push_back(q);
	endtask

	initial begin
		logic signed [W-1:0] mx, mn;
		request_t q;
		mx = {1'b0, {(W-1){1'b1}}};
		mn = {1'b1, {(W-1){1'b0}}};
		for (int a = 0; a < 4; a++) begin
			add_request(act_t'(a), mx, mx, mx, mx);
			add_request(act_t'(a), mn, mn, mn, mn);
			add_request(act_t'(a), mx, mn, mn, mx);
			add_request(act_t'(a), 32'sh18000, -32'sh8000, 32'sh10000, 32'sh1);
		end
		add_request(ACT_DIV, 32'sh10000, 32'sh20000, '0, '0);
		add_request(ACT_DIV, mn, mx, '0, '0);
		add_request(ACT_DIV, 32'sh10000, '0, 32'sh30000, '0);
		add_request(ACT_DIV, 32'sh1, '0, '0, 32'sh2);
		add_request(ACT_MUL, 32'sh8000, '0, 32'sh1, '0);
		add_request(ACT_MUL, -32'sh8000, '0, 32'sh1, '0);
		add_request(ACT_DIV, mx, mx, 32'sh1, '0);
		for (int i = 0; i < 400; i++) begin
			q.act = act_t'($urandom_range(0, 3));
			q.ar = rand_operand(); q.ai = rand_operand();
			q.br = rand_operand(); q.bi = rand_operand();
			if (q.act == ACT_DIV && $urandom_range(0, 15) == 0) begin
				q.br = '0; q.bi = '0;
			end
			pending.push_back(q);
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy && pending.size() > 0)
				void'(pending.pop_front());
			if (pending.size() == 0) begin
				start <= 1'b0;
				all_sent <= 1;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
				end
				burst_left--;
				if (burst_left == 0 && $urandom_range(0, 2) != 0)
					gap_left = $urandom_range(1, 6);
				start <= 1'b1;
				action <= pending[0].act;
				a_real <= pending[0].ar;
				a_imag <= pending[0].ai;
				b_real <= pending[0].br;
				b_imag <= pending[0].bi;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		request_t q;
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (start && !busy) begin
				q.act = act_t'(action); q.ar = a_real; q.ai = a_imag;
				q.br = b_real; q.bi = b_imag;
				awaited.push_back(complex_result(q));
			end
			if (done) begin
				if (awaited.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = awaited.pop_front();
					if (r_real !== e.re) begin
						$error("r_real expected %h actual %h", e.re, r_real);
						errors++;
					end
					if (r_imag !== e.im) begin
						$error("r_imag expected %h actual %h", e.im, r_imag);
						errors++;
					end
					if (status !== e.st) begin
						$error("status expected %0d actual %0d", e.st, status);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (all_sent && awaited.size() == 0);
				repeat (LATENCY + 10) @(posedge clk);
			end
			begin
				wait (idle_cycles >= STALL_LIMIT);
				errors++;
			end
		join_any
		if (awaited.size() != 0) begin
			$error("%0d results never arrived", awaited.size());
			errors++;
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
